// ----- rtl/core/sfir_pkg.sv -----
// Shared types and constants of the symmetric FIR low-pass filter.
package sfir_pkg;

    // Default number of taps held in the delay line
    localparam int unsigned MAX_TAPS_DEF = 64;

    // Field widths
    localparam int unsigned ORDER_W     = 6;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned COEF_W      = 18;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned CMD_W       = 2;

    // Register reset and rounding position (Q8.32 sum down to Q1.15)
    localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd32;
    localparam int unsigned        ROUND_SHIFT = 17;

    // Word kinds on the input stream
    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_CLEAR  = 2'd2
    } sfir_cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_EMIT
    } sfir_state_t;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;      // start of a new sum
        logic mul_en;   // operands valid this cycle
        logic last;     // operands are the final tap of the sum
    } sfir_mac_ctrl_t;

endpackage

// ----- rtl/core/sfir_hist_mem.sv -----
// Delay-line memory: one read and one write port, valid bit per entry.
module sfir_hist_mem
    import sfir_pkg::*;
#(
    parameter int unsigned DEPTH  = MAX_TAPS_DEF,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clr,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data
);

    logic signed [SAMPLE_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]           vld_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_vld_reg;

    // Storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // Valid bits: an entry never written since reset or clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/core/sfir_coef_mem.sv -----
// Coefficient memory: one write port, one registered read port.
module sfir_coef_mem
    import sfir_pkg::*;
#(
    parameter int unsigned DEPTH  = MAX_TAPS_DEF / 2 + 1,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic signed [COEF_W-1:0] rd_data,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic signed [COEF_W-1:0] wr_data
);

    logic signed [COEF_W-1:0] mem_reg [DEPTH];
    logic signed [COEF_W-1:0] rd_data_reg;

    // Storage array, read every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/sfir_mac.sv -----
// Multiply-accumulate unit with round-half-up and saturation to Q1.15.
module sfir_mac
    import sfir_pkg::*;
#(
    parameter int unsigned ACC_W = SAMPLE_W + COEF_W + 6
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sfir_mac_ctrl_t             ctrl,
    input  logic signed [SAMPLE_W-1:0] op_sample,
    input  logic signed [COEF_W-1:0]   op_coef,
    output logic                       done,
    output logic [SAMPLE_W-1:0]        res_sample,
    output logic                       res_sat
);

    localparam int unsigned PROD_W = SAMPLE_W + COEF_W;
    localparam int unsigned RND_W  = ACC_W + 1 - ROUND_SHIFT;
    localparam logic [ACC_W:0] ROUND_BIAS = (ACC_W + 1)'(1) << (ROUND_SHIFT - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_last_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     acc_last_reg;
    logic [RND_W-1:0]         rnd_reg;
    logic                     rnd_vld_reg;
    logic [SAMPLE_W-1:0]      res_sample_reg;
    logic                     res_sat_reg;
    logic                     done_reg;

    logic [ACC_W:0]              acc_ext;
    logic [RND_W-SAMPLE_W:0]     rnd_hi;
    logic                        in_range;
    logic [SAMPLE_W-1:0]         clamp_val;

    // Rounding: add half an LSB, then floor through the part-select
    assign acc_ext = {acc_reg[ACC_W-1], acc_reg} + ROUND_BIAS;

    // Saturation: in range when all bits from the sign of Q1.15 up agree
    assign rnd_hi    = rnd_reg[RND_W-1:SAMPLE_W-1];
    assign in_range  = (&rnd_hi) | ~(|rnd_hi);
    assign clamp_val = rnd_reg[RND_W-1] ? {1'b1, {(SAMPLE_W - 1){1'b0}}}
                                        : {1'b0, {(SAMPLE_W - 1){1'b1}}};

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= op_sample * op_coef;
        end
        if (ctrl.clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (acc_last_reg)
        begin
            rnd_reg <= acc_ext[ACC_W:ROUND_SHIFT];
        end
        if (rnd_vld_reg)
        begin
            res_sample_reg <= in_range ? rnd_reg[SAMPLE_W-1:0] : clamp_val;
            res_sat_reg    <= ~in_range;
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            acc_last_reg  <= 1'b0;
            rnd_vld_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            prod_vld_reg  <= ctrl.mul_en;
            prod_last_reg <= ctrl.mul_en & ctrl.last;
            acc_last_reg  <= prod_vld_reg & prod_last_reg;
            rnd_vld_reg   <= acc_last_reg;
            done_reg      <= rnd_vld_reg;
        end
    end

    assign done       = done_reg;
    assign res_sample = res_sample_reg;
    assign res_sat    = res_sat_reg;

endmodule

// ----- rtl/core/symmetric_fir_lowpass.sv -----
// Top level of the symmetric FIR low-pass filter: stream ports and sequencer.
//
// A sample word runs one sweep over the delay line, from the oldest tap in use
// down to the newest: each cycle one history entry is read, written back one
// place older (the new sample lands at place 0) and multiplied by the
// coefficient of its symmetric pair, so one multiplier serves every tap. The
// sweep covers length taps (length = tap_order + 1, at most MAX_TAPS); the sum
// then passes the MAC pipeline and the emit state into the output register.
// Load and clear words act in the idle state and give no result. A new word is
// accepted while an earlier result still waits on the output; the sweep stalls
// only at its end if that result has not been taken. Coefficients must be
// loaded before use; they have no reset value.
module symmetric_fir_lowpass
    import sfir_pkg::*;
#(
    parameter int unsigned MAX_TAPS = MAX_TAPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration: tap_order
    input  logic                cfg_we,
    input  logic [ORDER_W-1:0]  cfg_wdata,
    // Input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [39:0]         s_axis_tdata,   // sample_in[15:0], coef_index[21:16],
                                                // coef_value[39:22]
    input  logic [CMD_W-1:0]    s_axis_tuser,   // cmd[1:0]
    // Output stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // sample_out[15:0]
    output logic [0:0]          m_axis_tuser    // saturated[0]
);

    localparam int unsigned TAP_W      = $clog2(MAX_TAPS);
    localparam int unsigned COEF_SLOTS = MAX_TAPS / 2 + 1;
    localparam int unsigned CA_W       = $clog2(COEF_SLOTS);
    localparam int unsigned ACC_W      = SAMPLE_W + COEF_W + TAP_W;

    // Input word fields
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [IDX_W-1:0]           in_coef_index;
    logic signed [COEF_W-1:0]   in_coef_value;
    sfir_cmd_t                  in_cmd;

    assign in_sample     = s_axis_tdata[15:0];
    assign in_coef_index = s_axis_tdata[21:16];
    assign in_coef_value = s_axis_tdata[39:22];
    assign in_cmd        = sfir_cmd_t'(s_axis_tuser);

    // Registers
    sfir_state_t                state_reg, state_next;
    logic [ORDER_W-1:0]         tap_order_reg;
    logic [TAP_W-1:0]           j_reg, j_next;
    logic [TAP_W-1:0]           last_reg, last_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic                       p1_vld_reg;
    logic                       p1_first_reg;
    logic [TAP_W-1:0]           p1_idx_reg;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]        m_tdata_reg, m_tdata_next;
    logic                       m_tuser_reg, m_tuser_next;

    // Sequencer outputs
    logic                       in_acc;
    logic                       issue;
    logic                       hist_clr;
    logic                       coef_we;
    sfir_mac_ctrl_t             mac_ctrl;

    // Datapath nets
    logic [TAP_W-1:0]           last_idx;
    logic [TAP_W-1:0]           mirror;
    logic [TAP_W-1:0]           pair_idx;
    logic signed [SAMPLE_W-1:0] hist_rd_data;
    logic signed [SAMPLE_W-1:0] p1_val;
    logic signed [COEF_W-1:0]   coef_rd_data;
    logic                       mac_done;
    logic [SAMPLE_W-1:0]        mac_sample;
    logic                       mac_sat;
    logic                       out_free;

    // Index of the oldest tap in use
    assign last_idx = (32'(tap_order_reg) > 32'(MAX_TAPS - 1)) ? TAP_W'(MAX_TAPS - 1)
                                                               : TAP_W'(tap_order_reg);

    // Coefficient slot of the tap being swept: distance to the nearer end
    assign mirror   = last_reg - j_reg;
    assign pair_idx = (j_reg < mirror) ? j_reg : mirror;

    // Value written back at place p1_idx; also the multiplier operand
    assign p1_val = p1_first_reg ? x_reg : hist_rd_data;

    assign out_free = ~m_tvalid_reg | m_axis_tready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_order_reg <= ORDER_RESET;
        end
        else if (cfg_we)
        begin
            tap_order_reg <= cfg_wdata;
        end
    end

    // Sequencer state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            j_reg        <= '0;
            last_reg     <= '0;
            p1_vld_reg   <= 1'b0;
            p1_first_reg <= 1'b0;
            p1_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            j_reg        <= j_next;
            last_reg     <= last_next;
            p1_vld_reg   <= issue;
            p1_first_reg <= issue & (j_reg == '0);
            p1_idx_reg   <= j_reg;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        j_next          = j_reg;
        last_next       = last_reg;
        x_next          = x_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_axis_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        s_axis_tready   = 1'b0;
        in_acc          = 1'b0;
        issue           = 1'b0;
        hist_clr        = 1'b0;
        coef_we         = 1'b0;
        mac_ctrl.clr    = 1'b0;
        mac_ctrl.mul_en = p1_vld_reg;
        mac_ctrl.last   = p1_first_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                in_acc        = s_axis_tvalid;
                if (in_acc)
                begin
                    unique case (in_cmd)
                        CMD_SAMPLE:
                        begin
                            x_next       = in_sample;
                            last_next    = last_idx;
                            j_next       = last_idx;
                            mac_ctrl.clr = 1'b1;
                            state_next   = S_SWEEP;
                        end
                        CMD_LOAD:
                        begin
                            coef_we = (32'(in_coef_index) < 32'(COEF_SLOTS));
                        end
                        CMD_CLEAR:
                        begin
                            hist_clr = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                issue = 1'b1;
                if (j_reg == '0)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg - TAP_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = mac_sample;
                    m_tuser_next  = mac_sat;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // History: read one place newer, write back one place older
    sfir_hist_mem #(
        .DEPTH  (MAX_TAPS),
        .ADDR_W (TAP_W)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (hist_clr),
        .rd_en   (issue & (j_reg != '0)),
        .rd_addr (j_reg - TAP_W'(1)),
        .rd_data (hist_rd_data),
        .wr_en   (p1_vld_reg),
        .wr_addr (p1_idx_reg),
        .wr_data (p1_val)
    );

    // Coefficients
    sfir_coef_mem #(
        .DEPTH  (COEF_SLOTS),
        .ADDR_W (CA_W)
    ) u_coef (
        .clk     (clk),
        .rd_addr (CA_W'(pair_idx)),
        .rd_data (coef_rd_data),
        .wr_en   (coef_we),
        .wr_addr (CA_W'(in_coef_index)),
        .wr_data (in_coef_value)
    );

    // Shared multiply-accumulate
    sfir_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .op_sample  (p1_val),
        .op_coef    (coef_rd_data),
        .done       (mac_done),
        .res_sample (mac_sample),
        .res_sat    (mac_sat)
    );

    assign m_axis_tvalid   = m_tvalid_reg;
    assign m_axis_tdata    = m_tdata_reg;
    assign m_axis_tuser[0] = m_tuser_reg;

`ifndef SYNTHESIS
    // Write-back stage only follows a sweep cycle
    a_p1_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        p1_vld_reg |-> $past(state_reg == S_SWEEP))
        else $error("history write-back without a sweep step");

    // A finished sum arrives only while waiting for it
    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == S_DRAIN))
        else $error("accumulator result outside drain");

    // Sweep index never passes the oldest tap in use
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (j_reg <= last_reg))
        else $error("sweep index beyond filter length");

    // Emit with a free output slot presents a word and returns to idle
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && out_free) |=> (m_axis_tvalid && (state_reg == S_IDLE)))
        else $error("result not loaded into output register");
`endif

endmodule

// ----- verif/symmetric_fir_lowpass_checker.sv -----
// Scoreboard for the symmetric FIR low-pass filter: tracks both streams and checks each output word.
module symmetric_fir_lowpass_checker
    import sfir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [ORDER_W-1:0] cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [39:0]        in_data,     // sample_in, coef_index, coef_value
    input  logic [CMD_W-1:0]   in_kind,     // cmd
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [15:0]        out_data,    // sample_out
    input  logic [0:0]         out_flag,    // saturated
    output int                 mismatch_count,
    output int                 outputs_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COEF_SLOTS = MAX_TAPS_DEF / 2 + 1;
    localparam int unsigned IDX_LO     = SAMPLE_W;
    localparam int unsigned VAL_LO     = SAMPLE_W + IDX_W;
    localparam longint      HALF_LSB   = longint'(1) << (ROUND_SHIFT - 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic                clipped;
    } filter_out_t;

    // Shadow copy of the filter state
    logic [ORDER_W-1:0]         model_order;
    logic signed [SAMPLE_W-1:0] delay_line [MAX_TAPS_DEF];
    logic signed [COEF_W-1:0]   tap_coef [COEF_SLOTS];
    filter_out_t                expected_outputs [$];
    int                         fails = 0;
    int                         pending_cnt = 0;

    assign mismatch_count  = fails;
    assign outputs_pending = pending_cnt;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fails++;
    endtask

    // Shift one sample in and form the rounded, clamped symmetric sum
    function automatic filter_out_t filter_sample(input logic signed [SAMPLE_W-1:0] smp);
        int          len;
        int          half;
        longint      acc;
        longint      q;
        filter_out_t res;
        len = int'(model_order) + 1;
        if (len > MAX_TAPS_DEF)
            len = MAX_TAPS_DEF;
        half = len / 2;
        for (int i = len - 1; i > 0; i--)
            delay_line[i] = delay_line[i - 1];
        delay_line[0] = smp;
        acc = 0;
        // outer pairs first, slot 0 is the outermost pair
        for (int i = 0; i < half; i++)
            acc += (longint'(delay_line[i]) + longint'(delay_line[len - 1 - i]))
                   * longint'(tap_coef[i]);
        // odd length: centre tap uses the slot right after the pairs
        if (len % 2 == 1)
            acc += longint'(delay_line[half]) * longint'(tap_coef[half]);
        // round half up, then clamp to 16 bits
        q = (acc + HALF_LSB) >>> ROUND_SHIFT;
        res.clipped = 1'b0;
        if (q > 32767)
        begin
            q = 32767;
            res.clipped = 1'b1;
        end
        else if (q < -32768)
        begin
            q = -32768;
            res.clipped = 1'b1;
        end
        res.level = SAMPLE_W'(q);
        return res;
    endfunction

    // Sample both channels mid-cycle, where every signal is settled
    always @(negedge clk)
    begin
        filter_out_t want;
        logic [IDX_W-1:0] slot;
        if (!rst_n)
        begin
            model_order = ORDER_RESET;
            foreach (delay_line[i])
                delay_line[i] = '0;
            foreach (tap_coef[i])
                tap_coef[i] = '0;
            expected_outputs.delete();
        end
        else
        begin
            // output word taken at the coming edge
            if (out_valid && out_ready)
            begin
                if (expected_outputs.size() == 0)
                    report_mismatch($sformatf("output word %h/%b with nothing expected",
                                              out_data, out_flag));
                else
                begin
                    want = expected_outputs.pop_front();
                    if (out_data !== want.level)
                        report_mismatch($sformatf("sample_out %h, expected %h",
                                                  out_data, want.level));
                    if (out_flag[0] !== want.clipped)
                        report_mismatch($sformatf("saturated %b, expected %b",
                                                  out_flag[0], want.clipped));
                end
            end
            // order register
            if (cfg_we)
                model_order = cfg_wdata;
            // input word taken at the coming edge
            if (in_valid && in_ready)
            begin
                slot = in_data[IDX_LO +: IDX_W];
                case (in_kind)
                    CMD_SAMPLE:
                        expected_outputs.push_back(filter_sample(in_data[SAMPLE_W-1:0]));
                    CMD_LOAD:
                        if (slot < COEF_SLOTS)
                            tap_coef[slot] = in_data[VAL_LO +: COEF_W];
                    CMD_CLEAR:
                        foreach (delay_line[i])
                            delay_line[i] = '0;
                    default:
                        ;
                endcase
            end
        end
        pending_cnt = expected_outputs.size();
    end

endmodule

// ----- verif/symmetric_fir_lowpass_test.sv -----
// Testbench top for the symmetric FIR low-pass filter: clock, reset, stimulus, stalls, verdict.
module symmetric_fir_lowpass_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sfir_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;     // covers the longest sweep, over 64 taps
    localparam int HOLD_CYCLES    = 400;
    localparam int COEF_SLOTS     = MAX_TAPS_DEF / 2 + 1;
    localparam int COEF_MAX       = 131071;
    localparam int COEF_MIN       = -131072;
    localparam int COEF_SMALL     = 12000;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;   // unused kind, ignored by the block

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [ORDER_W-1:0] cfg_wdata     = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [39:0]        s_axis_tdata  = '0;     // sample_in, coef_index, coef_value
    logic [CMD_W-1:0]   s_axis_tuser  = '0;     // cmd
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;           // sample_out
    logic [0:0]         m_axis_tuser;           // saturated

    int mismatch_count;
    int outputs_pending;
    int source_idle_pct = 20;
    int sink_idle_pct   = 55;
    int pressure_seq    = 0;
    bit wide_coefs      = 1'b0;
    int quiet_cycles;

    logic [SAMPLE_W-1:0] corner_samples [6] =
        '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h7fff};

    symmetric_fir_lowpass uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    symmetric_fir_lowpass_checker fir_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_data         (s_axis_tdata),
        .in_kind         (s_axis_tuser),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_data        (m_axis_tdata),
        .out_flag        (m_axis_tuser),
        .mismatch_count  (mismatch_count),
        .outputs_pending (outputs_pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Output side: random stalls, plus a long hold-off on request
    initial
    begin
        int seen_seq;
        int hold_left;
        seen_seq  = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (pressure_seq != seen_seq)
            begin
                seen_seq  = pressure_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic logic [COEF_W-1:0] rand_coef();
        if (wide_coefs)
            return COEF_W'($urandom());
        return COEF_W'($urandom_range(0, 2 * COEF_SMALL) - COEF_SMALL);
    endfunction

    // Offer one word after a random gap; returns at the edge that takes it
    task automatic send_word(input logic [CMD_W-1:0] kind, input logic [SAMPLE_W-1:0] smp,
                             input logic [IDX_W-1:0] slot, input logic [COEF_W-1:0] value);
        logic taken;
        while ($urandom_range(0, 99) < source_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {value, slot, smp};
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Order register write, only while the block is idle
    task automatic write_order(input logic [ORDER_W-1:0] order);
        cfg_we    <= 1'b1;
        cfg_wdata <= order;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Wait for every expected word, then for a full sweep
    task automatic wait_quiet();
        while (outputs_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random mix, mostly samples; ignored words do not count
    task automatic send_random(input int count);
        int               sent;
        int               pick;
        logic [IDX_W-1:0] slot;
        logic [SAMPLE_W-1:0] smp;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                smp = SAMPLE_W'($urandom());
                if ($urandom_range(0, 9) == 0)
                    smp = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                send_word(CMD_SAMPLE, smp, IDX_W'($urandom()), COEF_W'($urandom()));
                sent++;
            end
            else if (pick < 90)
            begin
                if ($urandom_range(0, 9) == 0)
                    slot = IDX_W'($urandom_range(COEF_SLOTS, 63));
                else
                    slot = IDX_W'($urandom_range(0, COEF_SLOTS - 1));
                send_word(CMD_LOAD, SAMPLE_W'($urandom()), slot, rand_coef());
                if (slot < COEF_SLOTS)
                    sent++;
            end
            else if (pick < 95)
            begin
                send_word(CMD_CLEAR, SAMPLE_W'($urandom()), IDX_W'($urandom()),
                          COEF_W'($urandom()));
                sent++;
            end
            else
                send_word(CMD_NOP, SAMPLE_W'($urandom()), IDX_W'($urandom()),
                          COEF_W'($urandom()));
        end
    endtask

    // One setting of order, stall pattern and coefficient span
    task automatic run_phase(input logic [ORDER_W-1:0] order, input int src_pct,
                             input int dst_pct, input bit full_span, input bit squeeze,
                             input int count);
        wait_quiet();
        write_order(order);
        source_idle_pct = src_pct;
        sink_idle_pct   = dst_pct;
        wide_coefs      = full_span;
        if (squeeze)
            pressure_seq++;
        send_random(count);
        s_axis_tvalid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_order(ORDER_RESET);

        // every slot holds a value before any sample reads it
        for (int s = 0; s < COEF_SLOTS; s++)
            send_word(CMD_LOAD, SAMPLE_W'($urandom()), IDX_W'(s), rand_coef());

        // coefficient extremes: outermost pair and centre tap of the default length
        send_word(CMD_LOAD, '0, '0, COEF_W'(COEF_MAX));
        send_word(CMD_LOAD, '0, IDX_W'(ORDER_RESET / 2), COEF_W'(COEF_MIN));
        // loads past the last slot are dropped
        send_word(CMD_LOAD, '0, IDX_W'(COEF_SLOTS), COEF_W'(COEF_MIN));
        send_word(CMD_LOAD, '1, '1, '1);
        // sample extremes
        foreach (corner_samples[i])
            send_word(CMD_SAMPLE, corner_samples[i], '0, '0);
        // unused kind gives nothing, clear empties the line
        send_word(CMD_NOP, 16'h7fff, '0, '0);
        send_word(CMD_CLEAR, 16'h7fff, '0, '0);
        send_word(CMD_SAMPLE, 16'h8000, '1, '1);
        send_word(CMD_SAMPLE, 16'h7fff, '0, '0);
        s_axis_tvalid <= 1'b0;

        // order changes never clear the history
        run_phase(6'd63, 20, 55, 1'b0, 1'b1, 120);
        run_phase(6'd0,  55, 20, 1'b0, 1'b0, 60);
        run_phase(6'd1,  55, 20, 1'b1, 1'b0, 60);
        run_phase(6'd62, 0,  0,  1'b1, 1'b1, 120);
        run_phase(ORDER_W'($urandom_range(2, 61)), 0, 0, 1'b0, 1'b0, 120);
        run_phase(ORDER_W'($urandom_range(2, 61)), 0, 0, 1'b1, 1'b0, 120);

        wait_quiet();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
